// File: hw/rtl/sliding_window_median_top_defines.svh
// Assertion macros shared by the sliding window median RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define SWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swm assertion failed");

// Next-cycle implication, checked out of reset
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swm assertion failed");

`else

`define SWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/swm_pkg.sv
// Package for the sliding window median filter: defaults, FSM state type,
// and the controller-to-datapath command struct. No dependencies.
package swm_pkg;

    localparam int WINDOW_DEF      = 32;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int MEDIAN_BITS     = 12;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_CALC,
        S_EMIT
    } t_swm_state;

    // Commands issued by the controller each cycle
    typedef struct packed {
        logic capture;   // latch request sample, read the slot being replaced
        logic update;    // write ring slot, update sorted cells, advance pointer
        logic calc;      // form the median from the middle cells
        logic load_out;  // move the median into the output register
    } t_swm_cmd;

endpackage

// File: hw/rtl/sliding_window_median_top.sv
// Top level of the sliding window median filter.
// Depends on swm_pkg, swm_ctrl and swm_datapath.
//
//   channel | direction | handshake                         | payload
//   sample  | in        | i_sample_valid / o_sample_ready   | i_sample
//   median  | out       | o_median_valid / i_median_ready   | o_median
//
// Each request passes through four steps: accept and ring read, cell update,
// median calculation, output load. All WINDOW sorted cells update together.
// Synchronous active-low reset clears the ring valid bits, pointer and cells.
// A new request is taken while the previous median waits in the output
// register; a stalled output holds the next median in the emit state.
module sliding_window_median_top
    import swm_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_sample_valid,
    output logic                   o_sample_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_median_valid,
    input  logic                   i_median_ready,
    output logic [MEDIAN_BITS-1:0] o_median
);

    t_swm_cmd w_cmd;

    swm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .o_median_valid (o_median_valid),
        .i_median_ready (i_median_ready),
        .o_cmd          (w_cmd)
    );

    swm_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_sample (i_sample),
        .o_median (o_median)
    );

endmodule

// File: hw/rtl/swm_ctrl.sv
// Controller FSM for the sliding window median filter.
// Depends on swm_pkg and sliding_window_median_top_defines.svh.
`include "sliding_window_median_top_defines.svh"

module swm_ctrl
    import swm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_sample_valid,
    output logic     o_sample_ready,
    output logic     o_median_valid,
    input  logic     i_median_ready,
    output t_swm_cmd o_cmd
);

    t_swm_state r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_sample_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_sample_ready = 1'b1;
                if (i_sample_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // wait for the output slot to free up
                if (!r_out_valid || i_median_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when taken
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_median_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_median_valid = r_out_valid;

    `SWM_ASSERT_NEXT(a_accept_to_update, i_clk, i_rst_n, i_sample_valid && o_sample_ready, r_state == S_UPDATE)
    `SWM_ASSERT_NEXT(a_update_to_calc, i_clk, i_rst_n, r_state == S_UPDATE, r_state == S_CALC)
    `SWM_ASSERT_NEXT(a_emit_loads_out, i_clk, i_rst_n, o_cmd.load_out, r_out_valid && r_state == S_IDLE)
    `SWM_ASSERT_NOW(a_no_load_over_pending, i_clk, i_rst_n, o_cmd.load_out && r_out_valid, i_median_ready)

endmodule

// File: hw/rtl/swm_datapath.sv
// Datapath for the sliding window median filter: ring memory, sorted cell row,
// median arithmetic and output register. Depends on swm_pkg.
module swm_datapath
    import swm_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_swm_cmd               i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [MEDIAN_BITS-1:0] o_median
);

    localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MID = WINDOW / 2;

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [WINDOW-1:0]      r_vld;
    logic [SAMPLE_BITS-1:0] r_old_raw;
    logic                   r_old_vld;
    logic [PW-1:0]          r_wr_pos;
    logic [SAMPLE_BITS-1:0] r_sorted [WINDOW];
    logic [SAMPLE_BITS-1:0] n_sorted [WINDOW];
    logic [SAMPLE_BITS-1:0] r_med;
    logic [SAMPLE_BITS-1:0] n_med;
    logic [MEDIAN_BITS-1:0] r_median;
    logic [SAMPLE_BITS-1:0] w_old;

    // Capture the request and read the slot about to be replaced
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample  <= i_sample;
            r_old_raw <= r_mem[r_wr_pos];
        end
        if (i_cmd.update) begin
            r_mem[r_wr_pos] <= r_sample;
        end
    end

    // Slot valid bits and write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_old_vld <= 1'b0;
            r_wr_pos  <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_old_vld <= r_vld[r_wr_pos];
            end
            if (i_cmd.update) begin
                r_vld[r_wr_pos] <= 1'b1;
                if (r_wr_pos == PW'(WINDOW - 1)) begin
                    r_wr_pos <= '0;
                end else begin
                    r_wr_pos <= r_wr_pos + 1'b1;
                end
            end
        end
    end

    // Never-written slots hold zero
    assign w_old = r_old_vld ? r_old_raw : '0;

    // Sorted cell row: drop one copy of the old value, insert the new one
    for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
        logic [SAMPLE_BITS-1:0] w_prev;
        logic [SAMPLE_BITS-1:0] w_next;
        logic                   w_has_prev;
        logic                   w_has_next;

        if (gi > 0) begin : g_prev
            assign w_prev     = r_sorted[gi-1];
            assign w_has_prev = 1'b1;
        end else begin : g_no_prev
            assign w_prev     = '0;
            assign w_has_prev = 1'b0;
        end

        if (gi < WINDOW - 1) begin : g_next
            assign w_next     = r_sorted[gi+1];
            assign w_has_next = 1'b1;
        end else begin : g_no_next
            assign w_next     = '0;
            assign w_has_next = 1'b0;
        end

        always_comb begin
            n_sorted[gi] = r_sorted[gi];
            if (r_sample >= w_old) begin
                // cells between the removed copy and the insert point shift down
                if (r_sorted[gi] < w_old || r_sorted[gi] > r_sample) begin
                    n_sorted[gi] = r_sorted[gi];
                end else if (w_has_next && w_next <= r_sample) begin
                    n_sorted[gi] = w_next;
                end else begin
                    n_sorted[gi] = r_sample;
                end
            end else begin
                // cells between the insert point and the removed copy shift up
                if (r_sorted[gi] <= r_sample || r_sorted[gi] > w_old) begin
                    n_sorted[gi] = r_sorted[gi];
                end else if (w_has_prev && w_prev > r_sample) begin
                    n_sorted[gi] = w_prev;
                end else begin
                    n_sorted[gi] = r_sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_sorted[i] <= '0;
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_sorted[i] <= n_sorted[i];
            end
        end
    end

    // Median: middle cell, or floored mean of the two middle cells
    if (WINDOW % 2 == 1) begin : g_odd
        assign n_med = r_sorted[(WINDOW - 1) / 2];
    end else begin : g_even
        logic [SAMPLE_BITS:0] w_sum;
        assign w_sum = {1'b0, r_sorted[MID]} + {1'b0, r_sorted[MID-1]};
        assign n_med = w_sum[SAMPLE_BITS:1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_med <= n_med;
        end
        if (i_cmd.load_out) begin
            r_median <= MEDIAN_BITS'(r_med);
        end
    end

    assign o_median = r_median;

endmodule

// File: tb/sv/swm_median_checker.sv
// Checker for the sliding window median filter: watches both channels, keeps
// its own copy of the sample ring, predicts each median and compares.
// Depends on swm_pkg for the median width.
`timescale 1ns / 1ps

module swm_median_checker
    import swm_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_sample_valid,
    input  logic                   i_sample_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_median_valid,
    input  logic                   i_median_ready,
    input  logic [MEDIAN_BITS-1:0] i_median,
    output int                     o_mismatch_count,
    output int                     o_pending_count
);

    // Shadow copy of the ring and the slot the next sample replaces
    logic [SAMPLE_BITS-1:0] ring [WINDOW];
    int                     ring_pos;
    logic [MEDIAN_BITS-1:0] expected_medians [$];

    // Median of the shadow ring: sort a copy, take the middle (or the
    // floored mean of the two middle entries for an even window)
    function automatic logic [MEDIAN_BITS-1:0] ring_median();
        logic [SAMPLE_BITS-1:0] sorted [WINDOW];
        logic [SAMPLE_BITS-1:0] v;
        logic [SAMPLE_BITS:0]   pair_sum;
        int                     k;
        for (int i = 0; i < WINDOW; i++) begin
            v = ring[i];
            k = i;
            while (k > 0 && sorted[k-1] > v) begin
                sorted[k] = sorted[k-1];
                k--;
            end
            sorted[k] = v;
        end
        if (WINDOW % 2 != 0) begin
            return MEDIAN_BITS'(sorted[(WINDOW-1)/2]);
        end
        pair_sum = {1'b0, sorted[WINDOW/2]} + {1'b0, sorted[WINDOW/2-1]};
        return MEDIAN_BITS'(pair_sum >> 1);
    endfunction

    // Insert an accepted sample and queue the median it produces
    task automatic take_sample(input logic [SAMPLE_BITS-1:0] s);
        if (ring_pos >= WINDOW) begin
            ring_pos = 0;
        end
        ring[ring_pos] = s;
        ring_pos++;
        if (ring_pos >= WINDOW) begin
            ring_pos = 0;
        end
        expected_medians.push_back(ring_median());
    endtask

    // Result side is checked before the request side: a median can never
    // belong to a request accepted at the same edge
    always @(posedge i_clk) begin
        logic [MEDIAN_BITS-1:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring[i] = '0;
            end
            ring_pos = 0;
            expected_medians.delete();
        end else begin
            if (i_median_valid && i_median_ready) begin
                if (expected_medians.size() == 0) begin
                    $display("%0t: unexpected median, expected none, actual %0d",
                             $time, i_median);
                    o_mismatch_count <= o_mismatch_count + 1;
                end else begin
                    want = expected_medians.pop_front();
                    if (i_median !== want) begin
                        $display("%0t: median mismatch, expected %0d, actual %0d",
                                 $time, want, i_median);
                        o_mismatch_count <= o_mismatch_count + 1;
                    end
                end
            end
            if (i_sample_valid && i_sample_ready) begin
                take_sample(i_sample);
            end
        end
        o_pending_count <= expected_medians.size();
    end

endmodule

// File: tb/sv/tb_sliding_window_median_top.sv
// Testbench top for the sliding window median filter: drives sample requests
// in bursts, stalls the median side, and reports the verdict.
// Depends on swm_pkg, sliding_window_median_top and swm_median_checker.
`timescale 1ns / 1ps

module tb_sliding_window_median_top
    import swm_pkg::*;
();

    localparam int WINDOW       = WINDOW_DEF;
    localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
    localparam int RANDOM_ITEMS = 500;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_sample_valid = 1'b0;
    logic [SAMPLE_BITS-1:0] i_sample       = '0;
    logic                   i_median_ready = 1'b1;
    logic                   o_sample_ready;
    logic                   o_median_valid;
    logic [MEDIAN_BITS-1:0] o_median;
    int                     mismatch_count;
    int                     pending_count;

    // Receiver stall pattern: mode picked every so often
    int                     stall_mode  = 0;
    int                     stall_ticks = 0;
    logic [SAMPLE_BITS-1:0] drift_level = '0;

    sliding_window_median_top #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_median_valid (o_median_valid),
        .i_median_ready (i_median_ready),
        .o_median       (o_median)
    );

    swm_median_checker #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample_valid   (i_sample_valid),
        .i_sample_ready   (o_sample_ready),
        .i_sample         (i_sample),
        .i_median_valid   (o_median_valid),
        .i_median_ready   (i_median_ready),
        .i_median         (o_median),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Median side: always ready, coin flip, or mostly stalled
    always @(posedge i_clk) begin
        stall_ticks <= stall_ticks + 1;
        if (stall_ticks % 150 == 0) begin
            stall_mode <= $urandom_range(0, 2);
        end
        case (stall_mode)
            0: begin
                i_median_ready <= 1'b1;
            end
            1: begin
                i_median_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_median_ready <= ($urandom_range(0, 5) == 0);
            end
        endcase
    end

    // Drive one request and hold it until accepted
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        @(posedge i_clk);
        while (!o_sample_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Drop valid and sit until every queued median has come out
    task automatic wait_drained();
        i_sample_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random sample: plain random, rail values, single-bit patterns,
    // small values, or a slowly drifting level so the median moves
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int roll;
        int bit_sel;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        end else if (roll < 50) begin
            return $urandom_range(0, 1) ? SAMPLE_MAX : '0;
        end else if (roll < 62) begin
            bit_sel = $urandom_range(0, SAMPLE_BITS - 1);
            return $urandom_range(0, 1) ? (SAMPLE_BITS'(1) << bit_sel)
                                        : ~(SAMPLE_BITS'(1) << bit_sel);
        end else if (roll < 72) begin
            return SAMPLE_BITS'($urandom_range(0, 7));
        end
        if ($urandom_range(0, 15) == 0) begin
            drift_level = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        end
        return drift_level ^ SAMPLE_BITS'($urandom_range(0, 31));
    endfunction

    initial begin
        logic [SAMPLE_BITS-1:0] directed_samples [$];
        int                     sent;
        int                     burst_len;
        int                     gap_len;
        bit                     drained_once;

        // Rails, alternating bits, mid-scale around the carry, then a run of
        // full-scale samples so the window goes from mostly empty to mostly full
        // and the even-window mean crosses an odd sum
        directed_samples = '{12'd0, 12'hFFF, 12'd1, 12'hFFE, 12'hAAA, 12'h555,
                             12'h800, 12'h7FF};
        for (int i = 0; i < 15; i++) begin
            directed_samples.push_back(SAMPLE_MAX);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_samples[i]) begin
            send_sample(directed_samples[i]);
        end

        sent         = 0;
        drained_once = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(1, 12);
            for (int b = 0; b < burst_len && sent < RANDOM_ITEMS; b++) begin
                send_sample(pick_sample());
                sent++;
            end
            if (!drained_once && sent >= RANDOM_ITEMS / 2) begin
                wait_drained();
                drained_once = 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
                gap_len = $urandom_range(1, 8);
                i_sample_valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sliding_window_median_top.f
+incdir+hw/rtl
hw/rtl/swm_pkg.sv
hw/rtl/swm_ctrl.sv
hw/rtl/swm_datapath.sv
hw/rtl/sliding_window_median_top.sv
tb/sv/swm_median_checker.sv
tb/sv/tb_sliding_window_median_top.sv
